>>> rtl/footprint_clip_and_test_defines.svh
// Assertion macros for the footprint clip and test block
`ifndef FOOTPRINT_CLIP_AND_TEST_DEFINES_SVH
`define FOOTPRINT_CLIP_AND_TEST_DEFINES_SVH

// check while out of reset
`define FCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check in and out of reset
`define FCT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/fct_pkg.sv
// Types, widths and helpers shared by the footprint clip and test block
`timescale 1ns / 1ps
package fct_pkg;

    localparam int COORD_BITS = 24;
    localparam int DW  = COORD_BITS + 1;
    localparam int SW  = 2 * DW;
    localparam int RMW = DW + 3;
    localparam int PW  = DW + COORD_BITS - 1;
    localparam int EW  = COORD_BITS + 2;

    typedef enum logic [1:0] {
        KIND_SPHERE   = 2'd0,
        KIND_CYLINDER = 2'd1,
        KIND_BOX      = 2'd2,
        KIND_NONE     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_KIND  = 2'd0,
        REG_MAJOR = 2'd1,
        REG_MINOR = 2'd2,
        REG_SPARE = 2'd3
    } t_reg;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic signed [COORD_BITS-1:0] query_x;
        logic signed [COORD_BITS-1:0] query_y;
    } t_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] clipped_x;
        logic signed [COORD_BITS-1:0] clipped_y;
        logic                         inside_res;
    } t_out;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic                         neg_x;
        logic                         neg_y;
        logic                         in_fp;
        logic                         pull;
        logic [PW-1:0]                pax;
        logic [PW-1:0]                pay;
    } t_carry;

    typedef struct packed {
        logic [SW-1:0]  s;
        logic [RMW-1:0] rem;
        logic [DW-1:0]  root;
        t_carry         c;
    } t_sq;

    typedef struct packed {
        logic [DW-1:0] r;
        logic [DW-1:0] remx;
        logic [DW-1:0] remy;
        logic [DW-1:0] lx;
        logic [DW-1:0] ly;
        logic [DW-1:0] qx;
        logic [DW-1:0] qy;
        t_carry        c;
    } t_dv;

    localparam logic signed [EW-1:0] SAT_HI = EW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

    function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] t;
        t = v;
        if (v > SAT_HI) t = SAT_HI;
        if (v < SAT_LO) t = SAT_LO;
        return t[COORD_BITS-1:0];
    endfunction

endpackage

>>> rtl/fct_sqrt_cell.sv
// One digit cell of the pipelined integer square root chain
`timescale 1ns / 1ps
module fct_sqrt_cell (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_vld,
    input  fct_pkg::t_sq i_d,
    output logic         o_vld,
    output fct_pkg::t_sq o_d
);
    logic [fct_pkg::RMW-1:0] rem_sh;
    logic [fct_pkg::RMW-1:0] trial;
    logic                    ge;
    fct_pkg::t_sq            n_d;
    fct_pkg::t_sq            r_d;
    logic                    r_vld;

    always_comb begin
        rem_sh = {i_d.rem[fct_pkg::RMW-3:0], i_d.s[fct_pkg::SW-1:fct_pkg::SW-2]};
        trial  = {1'b0, i_d.root, 2'b01};
        ge     = rem_sh >= trial;
        n_d      = i_d;
        n_d.s    = {i_d.s[fct_pkg::SW-3:0], 2'b00};
        n_d.rem  = ge ? rem_sh - trial : rem_sh;
        n_d.root = {i_d.root[fct_pkg::DW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;
endmodule

>>> rtl/fct_div_cell.sv
// One quotient bit cell of the pipelined dual-axis divider chain
`timescale 1ns / 1ps
module fct_div_cell (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_vld,
    input  fct_pkg::t_dv i_d,
    output logic         o_vld,
    output fct_pkg::t_dv o_d
);
    logic [fct_pkg::DW:0] nx;
    logic [fct_pkg::DW:0] ny;
    logic [fct_pkg::DW:0] dv;
    logic                 gex;
    logic                 gey;
    logic [fct_pkg::DW:0] subx;
    logic [fct_pkg::DW:0] suby;
    fct_pkg::t_dv         n_d;
    fct_pkg::t_dv         r_d;
    logic                 r_vld;

    always_comb begin
        nx   = {i_d.remx, i_d.lx[fct_pkg::DW-1]};
        ny   = {i_d.remy, i_d.ly[fct_pkg::DW-1]};
        dv   = {1'b0, i_d.r};
        gex  = nx >= dv;
        gey  = ny >= dv;
        subx = gex ? nx - dv : nx;
        suby = gey ? ny - dv : ny;
        n_d      = i_d;
        n_d.remx = subx[fct_pkg::DW-1:0];
        n_d.remy = suby[fct_pkg::DW-1:0];
        n_d.lx   = {i_d.lx[fct_pkg::DW-2:0], 1'b0};
        n_d.ly   = {i_d.ly[fct_pkg::DW-2:0], 1'b0};
        n_d.qx   = {i_d.qx[fct_pkg::DW-2:0], gex};
        n_d.qy   = {i_d.qy[fct_pkg::DW-2:0], gey};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;
endmodule

>>> rtl/footprint_clip_and_test.sv
// Top level: footprint test and clip of a query point against a circle or a box
// Path: input, difference and square registers, then a square root chain and a divider
// chain of COORD_BITS+1 cells each, one result bit per cell, then the output register.
// Throughput: one word per cycle while the output register is not stalled.
// The whole pipeline advances when the output register is empty or being taken.
// Reset: synchronous, active low; clears every valid bit and the config registers to zero.
`timescale 1ns / 1ps
module footprint_clip_and_test (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [fct_pkg::COORD_BITS-2:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  fct_pkg::t_in                  i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output fct_pkg::t_out                 o_out
);
    localparam int CB = fct_pkg::COORD_BITS;
    localparam int DW = fct_pkg::DW;
    localparam int SW = fct_pkg::SW;
    localparam int PW = fct_pkg::PW;
    localparam int EW = fct_pkg::EW;

    fct_pkg::t_kind          r_kind;
    logic [CB-2:0]           r_major;
    logic [CB-2:0]           r_minor;
    logic [2*(CB-1)-1:0]     r_rr;

    logic                    en;

    logic                    r_v0;
    fct_pkg::t_in            r_in0;

    logic signed [DW-1:0]    dx;
    logic signed [DW-1:0]    dy;
    logic signed [EW-1:0]    lox;
    logic signed [EW-1:0]    hix;
    logic signed [EW-1:0]    loy;
    logic signed [EW-1:0]    hiy;
    logic signed [EW-1:0]    qxe;
    logic signed [EW-1:0]    qye;
    logic signed [EW-1:0]    clx;
    logic signed [EW-1:0]    cly;
    logic                    box_in;
    logic                    circ;

    logic                    r_v1;
    logic [DW-1:0]           r_ax;
    logic [DW-1:0]           r_ay;
    logic                    r_circ1;
    fct_pkg::t_carry         r_c1;
    fct_pkg::t_carry         n_c1;

    logic                    r_v2;
    logic [SW-1:0]           r_sx;
    logic [SW-1:0]           r_sy;
    logic                    r_circ2;
    fct_pkg::t_carry         r_c2;
    fct_pkg::t_carry         n_c2;

    logic [SW-1:0]           s;
    logic                    in_c;
    fct_pkg::t_sq            sq_head;

    logic                    sq_vld [DW+1];
    fct_pkg::t_sq            sq_d   [DW+1];
    logic                    dv_vld [DW+1];
    fct_pkg::t_dv            dv_d   [DW+1];

    fct_pkg::t_dv            dv_head;
    fct_pkg::t_dv            dv_tail;
    logic signed [EW-1:0]    offx;
    logic signed [EW-1:0]    offy;
    fct_pkg::t_out           res;

    logic                    r_ovld;
    fct_pkg::t_out           r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= fct_pkg::KIND_SPHERE;
            r_major <= '0;
            r_minor <= '0;
            r_rr    <= '0;
        end else begin
            r_rr <= r_major * r_major;
            if (i_cfg_we) begin
                unique case (fct_pkg::t_reg'(i_cfg_idx))
                    fct_pkg::REG_KIND:  r_kind  <= fct_pkg::t_kind'(i_cfg_data[1:0]);
                    fct_pkg::REG_MAJOR: r_major <= i_cfg_data;
                    fct_pkg::REG_MINOR: r_minor <= i_cfg_data;
                    fct_pkg::REG_SPARE: r_kind  <= r_kind;
                endcase
            end
        end
    end

    assign en         = !r_ovld || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_in_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_comb begin
        dx   = DW'(r_in0.query_x) - DW'(r_in0.center_x);
        dy   = DW'(r_in0.query_y) - DW'(r_in0.center_y);
        qxe  = EW'(r_in0.query_x);
        qye  = EW'(r_in0.query_y);
        lox  = EW'(r_in0.center_x) - $signed({3'b000, r_major});
        hix  = EW'(r_in0.center_x) + $signed({3'b000, r_major});
        loy  = EW'(r_in0.center_y) - $signed({3'b000, r_minor});
        hiy  = EW'(r_in0.center_y) + $signed({3'b000, r_minor});
        clx  = qxe;
        cly  = qye;
        if (qxe < lox) clx = lox;
        if (qxe > hix) clx = hix;
        if (qye < loy) cly = loy;
        if (qye > hiy) cly = hiy;
        box_in = (qxe >= lox) && (qxe <= hix) && (qye >= loy) && (qye <= hiy);
        circ   = (r_kind == fct_pkg::KIND_SPHERE) || (r_kind == fct_pkg::KIND_CYLINDER);
        n_c1        = '0;
        n_c1.cx     = r_in0.center_x;
        n_c1.cy     = r_in0.center_y;
        n_c1.neg_x  = dx[DW-1];
        n_c1.neg_y  = dy[DW-1];
        n_c1.bx     = r_in0.query_x;
        n_c1.by     = r_in0.query_y;
        if (r_kind == fct_pkg::KIND_BOX) begin
            n_c1.bx     = fct_pkg::sat(clx);
            n_c1.by     = fct_pkg::sat(cly);
            n_c1.in_fp  = box_in;
        end
    end

    always_comb begin
        n_c2     = r_c1;
        n_c2.pax = PW'(r_ax * r_major);
        n_c2.pay = PW'(r_ay * r_major);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in0   <= i_in;
            r_ax    <= dx[DW-1] ? DW'(-dx) : DW'(dx);
            r_ay    <= dy[DW-1] ? DW'(-dy) : DW'(dy);
            r_circ1 <= circ;
            r_c1    <= n_c1;
            r_sx    <= SW'(r_ax * r_ax);
            r_sy    <= SW'(r_ay * r_ay);
            r_circ2 <= r_circ1;
            r_c2    <= n_c2;
        end
    end

    always_comb begin
        s    = r_sx + r_sy;
        in_c = s <= SW'(r_rr);
        sq_head        = '0;
        sq_head.s      = s;
        sq_head.c      = r_c2;
        if (r_circ2) begin
            sq_head.c.in_fp = in_c;
            sq_head.c.pull  = !in_c;
        end
    end

    assign sq_vld[0] = r_v2;
    assign sq_d[0]   = sq_head;

    for (genvar g = 0; g < DW; g++) begin : g_sqrt
        fct_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (sq_vld[g]),
            .i_d     (sq_d[g]),
            .o_vld   (sq_vld[g+1]),
            .o_d     (sq_d[g+1])
        );
    end

    always_comb begin
        dv_head      = '0;
        dv_head.c    = sq_d[DW].c;
        dv_head.r    = (sq_d[DW].root == '0) ? DW'(1) : sq_d[DW].root;
        dv_head.remx = DW'(sq_d[DW].c.pax[PW-1:DW]);
        dv_head.remy = DW'(sq_d[DW].c.pay[PW-1:DW]);
        dv_head.lx   = sq_d[DW].c.pax[DW-1:0];
        dv_head.ly   = sq_d[DW].c.pay[DW-1:0];
    end

    assign dv_vld[0] = sq_vld[DW];
    assign dv_d[0]   = dv_head;

    for (genvar g = 0; g < DW; g++) begin : g_div
        fct_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (dv_vld[g]),
            .i_d     (dv_d[g]),
            .o_vld   (dv_vld[g+1]),
            .o_d     (dv_d[g+1])
        );
    end

    always_comb begin
        dv_tail = dv_d[DW];
        offx = dv_tail.c.neg_x ? -$signed(EW'(dv_tail.qx)) : $signed(EW'(dv_tail.qx));
        offy = dv_tail.c.neg_y ? -$signed(EW'(dv_tail.qy)) : $signed(EW'(dv_tail.qy));
        res.inside_res = dv_tail.c.in_fp;
        res.clipped_x  = dv_tail.c.bx;
        res.clipped_y  = dv_tail.c.by;
        if (dv_tail.c.pull) begin
            res.clipped_x = fct_pkg::sat(EW'(dv_tail.c.cx) + offx);
            res.clipped_y = fct_pkg::sat(EW'(dv_tail.c.cy) + offy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= dv_vld[DW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out       = r_out;
endmodule

>>> rtl/fct_checker.sv
// Port-level assertion checker for the footprint clip and test block
`timescale 1ns / 1ps
`include "footprint_clip_and_test_defines.svh"
module fct_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [1:0]                     i_cfg_idx,
    input logic [fct_pkg::COORD_BITS-2:0] i_cfg_data,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input fct_pkg::t_in                   i_in,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input fct_pkg::t_out                  o_out
);
    `FCT_ASSERT_ALWAYS(a_rst_clears_out, !i_rst_n |=> !o_out_valid, "output valid after reset")
    `FCT_ASSERT(a_ready_follows_out, o_in_ready == (!o_out_valid || i_out_ready), "input ready not tied to output stall")
    `FCT_ASSERT(a_out_held, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out), "output word dropped while stalled")
endmodule

bind footprint_clip_and_test fct_checker u_fct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_idx   (i_cfg_idx),
    .i_cfg_data  (i_cfg_data),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

>>> tb/sv/tb.sv
// Testbench for footprint_clip_and_test: predicted clip and inside flag per word, checked in order
`timescale 1ns / 1ps
module tb;
    import fct_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int LAT = 2 * (CB + 1) + 4;
    localparam longint LIMIT = 400000;

    class clip_board;
        t_out pending[$];
        int   errors;
        int   matched;
        t_kind kind;
        longint rmaj, rmin;

        function automatic longint sat_coord(longint v);
            longint hi, lo;
            hi = (64'sd1 <<< (CB - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        function automatic longint unsigned isqrt(longint unsigned s);
            longint unsigned root, bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > s) bitv >>= 2;
            while (bitv != 0) begin
                if (s >= root + bitv) begin
                    s -= root + bitv;
                    root = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            return root;
        endfunction

        function automatic longint pull(longint c, longint d, longint unsigned r);
            longint unsigned ad, q;
            ad = (d < 0) ? -d : d;
            q = (ad * rmaj) / r;
            return (d < 0) ? c - longint'(q) : c + longint'(q);
        endfunction

        function void note_word(t_in w);
            longint cx, cy, qx, qy, rx, ry, dx, dy, lox, hix, loy, hiy;
            longint unsigned s, r;
            bit ins;
            t_out e;
            cx = w.center_x; cy = w.center_y; qx = w.query_x; qy = w.query_y;
            rx = qx; ry = qy; ins = 0;
            if (kind == KIND_SPHERE || kind == KIND_CYLINDER) begin
                dx = qx - cx; dy = qy - cy;
                s = dx * dx + dy * dy;
                ins = (s <= rmaj * rmaj);
                if (!ins) begin
                    r = isqrt(s);
                    if (r == 0) r = 1;
                    rx = pull(cx, dx, r);
                    ry = pull(cy, dy, r);
                end
            end else if (kind == KIND_BOX) begin
                lox = cx - rmaj; hix = cx + rmaj; loy = cy - rmin; hiy = cy + rmin;
                ins = (qx >= lox && qx <= hix && qy >= loy && qy <= hiy);
                rx = (qx < lox) ? lox : (qx > hix) ? hix : qx;
                ry = (qy < loy) ? loy : (qy > hiy) ? hiy : qy;
            end
            e.clipped_x = sat_coord(rx);
            e.clipped_y = sat_coord(ry);
            e.inside_res = ins;
            pending.push_back(e);
        endfunction

        function void check_word(t_out a);
            t_out e;
            if (pending.size() == 0) begin
                $error("unexpected output word %h", a);
                errors++;
                return;
            end
            e = pending.pop_front();
            matched++;
            if (a.clipped_x !== e.clipped_x) begin
                $error("clipped_x expected %0d actual %0d", e.clipped_x, a.clipped_x);
                errors++;
            end
            if (a.clipped_y !== e.clipped_y) begin
                $error("clipped_y expected %0d actual %0d", e.clipped_y, a.clipped_y);
                errors++;
            end
            if (a.inside_res !== e.inside_res) begin
                $error("inside_res expected %0d actual %0d", e.inside_res, a.inside_res);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_cfg_we, i_in_valid, o_in_ready, o_out_valid, i_out_ready;
    logic [1:0] i_cfg_idx;
    logic [CB-2:0] i_cfg_data;
    t_in i_in;
    t_out o_out;

    clip_board board;
    int send_idle_pct, recv_stall_pct;
    bit hold_off;
    longint cycles;
    int sent;

    footprint_clip_and_test i_dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("footprint_clip_and_test regression: fail");
                $finish;
            end
        end
    end

    // receiver side
    initial begin
        i_out_ready = 0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) board.check_word(o_out);
    end

    task automatic write_reg(t_reg idx, logic [CB-2:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            REG_KIND:  board.kind = t_kind'(v[1:0]);
            REG_MAJOR: board.rmaj = v;
            REG_MINOR: board.rmin = v;
            default: ;
        endcase
    endtask

    task automatic send_word(t_in w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_in_valid <= 1; i_in <= w;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_word(w);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    function automatic logic [CB-1:0] rnd_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(1, 0) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
            default: return CB'($signed($urandom_range(4000)) - 2000);
        endcase
    endfunction

    function automatic t_in rnd_word();
        t_in w;
        logic [CB-1:0] c;
        c = rnd_coord($urandom_range(2));
        w.center_x = c;
        w.center_y = rnd_coord($urandom_range(2));
        w.query_x = $urandom_range(1) ? rnd_coord($urandom_range(2))
                                      : c + CB'($signed($urandom_range(600)) - 300);
        w.query_y = rnd_coord($urandom_range(2));
        return w;
    endfunction

    function automatic t_in mk(int cx, int cy, int qx, int qy);
        t_in w;
        w.center_x = cx; w.center_y = cy; w.query_x = qx; w.query_y = qy;
        return w;
    endfunction

    task automatic set_shape(t_kind k, logic [CB-2:0] ma, logic [CB-2:0] mi);
        write_reg(REG_KIND, k);
        write_reg(REG_MAJOR, ma);
        write_reg(REG_MINOR, mi);
    endtask

    initial begin
        int maxc, minc;
        logic [CB-2:0] rmax;
        board = new();
        board.kind = KIND_SPHERE; board.rmaj = 0; board.rmin = 0;
        maxc = (1 << (CB - 1)) - 1; minc = -(1 << (CB - 1));
        rmax = '1;
        hold_off = 0; send_idle_pct = 0; recv_stall_pct = 0; sent = 0;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_idx = REG_KIND; i_cfg_data = 0;
        i_in_valid = 0; i_in = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: zero radius circle, boundary, extremes, box, none
        send_word(mk(0, 0, 0, 0));
        send_word(mk(0, 0, 100, -50));
        drain();
        set_shape(KIND_SPHERE, 500, 0);
        send_word(mk(0, 0, 300, 400));
        send_word(mk(0, 0, 301, 400));
        send_word(mk(10, -10, 10, -10));
        send_word(mk(minc, minc, maxc, maxc));
        send_word(mk(maxc, maxc, minc, minc));
        drain();
        set_shape(KIND_CYLINDER, rmax, 0);
        send_word(mk(maxc, 0, minc, 0));
        send_word(mk(minc, minc, maxc, maxc));
        send_word(mk(maxc, maxc, maxc, minc));
        drain();
        set_shape(KIND_BOX, 100, 0);
        send_word(mk(0, 0, 100, 0));
        send_word(mk(0, 0, 101, 1));
        send_word(mk(0, 0, -101, -1));
        drain();
        set_shape(KIND_BOX, rmax, rmax);
        send_word(mk(maxc, maxc, minc, minc));
        send_word(mk(minc, minc, maxc, maxc));
        drain();
        set_shape(KIND_NONE, 7, 9);
        send_word(mk(0, 0, maxc, minc));
        send_word(mk(minc, maxc, 5, -5));
        drain();
        write_reg(REG_SPARE, rmax);

        // random phases over several settings
        for (int ph = 0; ph < 12; ph++) begin
            int kc;
            kc = ph % 4;
            case (ph % 3)
                0: set_shape(t_kind'(kc), $urandom_range(2000), $urandom_range(2000));
                1: set_shape(t_kind'(kc), $urandom, $urandom);
                default: set_shape(t_kind'(kc), (ph < 6) ? 0 : rmax, (ph < 6) ? rmax : 0);
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 51; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 51; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            if (ph == 4) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (300) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            repeat (73) send_word(rnd_word());
            drain();
        end

        send_idle_pct = 0; recv_stall_pct = 0;
        drain();
        $display("sent %0d words over all shape kinds, zero and full radii, with idle and stall",
                 sent);
        $display("checked %0d output words", board.matched);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("footprint_clip_and_test regression: pass");
        end else begin
            $display("footprint_clip_and_test regression: fail");
        end
        $finish;
    end
endmodule
